FILE: rtl/core/mjq_pkg.sv
// ----------------------------------------------------------------------------
// mjq_pkg
// Shared types, widths and helpers for the minimum-jerk quintic coefficient
// pipeline.
// ----------------------------------------------------------------------------
package mjq_pkg;

	// Field widths
	localparam int DATA_W    = 48;
	localparam int DUR_W     = 32;
	localparam int FRAC_BITS = 24;

	// Request transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] start_pos;
		logic signed [DATA_W-1:0] start_vel;
		logic signed [DATA_W-1:0] start_acc;
		logic signed [DATA_W-1:0] end_pos;
		logic signed [DATA_W-1:0] end_vel;
		logic signed [DATA_W-1:0] end_acc;
		logic        [DUR_W-1:0]  duration;
	} in_t;

	// Result transaction
	typedef struct packed {
		logic signed [DATA_W-1:0] coef0;
		logic signed [DATA_W-1:0] coef1;
		logic signed [DATA_W-1:0] coef2;
		logic signed [DATA_W-1:0] coef3;
		logic signed [DATA_W-1:0] coef4;
		logic signed [DATA_W-1:0] coef5;
		logic                     fault;
	} out_t;

	// Larger of two widths, for elaboration-time sizing
	function automatic int wmax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Apply sign to an unsigned quotient and clamp to the signed range.
	// Returns {saturated, value}.
	function automatic logic [DATA_W:0] sat_coef(input logic [DATA_W:0] q, input logic neg);
		logic [DATA_W:0]   lim;
		logic              flag;
		logic [DATA_W-1:0] val;
		lim = (DATA_W+1)'(1) << (DATA_W-1);
		if (neg) begin
			flag = (q > lim);
			val  = flag ? lim[DATA_W-1:0] : DATA_W'((~q) + 1'b1);
		end else begin
			flag = (q >= lim);
			val  = flag ? DATA_W'(lim - 1'b1) : q[DATA_W-1:0];
		end
		return {flag, val};
	endfunction

endpackage

FILE: rtl/core/mjq_mul.sv
// ----------------------------------------------------------------------------
// mjq_mul
// Two-stage signed-by-unsigned multiplier: 33x33 partial products in the
// first stage, shifted sum in the second.
// ----------------------------------------------------------------------------
module mjq_mul #(
	parameter int WA = 48
) (
	input  logic                                  clk,
	input  logic signed [WA-1:0]                  a,
	input  logic        [mjq_pkg::DUR_W-1:0]      b,
	output logic signed [WA+mjq_pkg::DUR_W-1:0]   p
);
	localparam int CW = mjq_pkg::DUR_W;
	localparam int NC = (WA + CW - 1) / CW;
	localparam int LW = WA - CW * (NC - 1);
	localparam int PW = WA + CW;

	logic signed [2*CW+1:0] part_s1 [NC];
	logic signed [PW-1:0]   sum;
	logic signed [PW-1:0]   p_s2;

	// Partial products, one chunk of a each
	for (genvar i = 0; i < NC; i++) begin : g_part
		logic signed [CW:0] ax;
		if (i < NC - 1) begin : g_lo
			assign ax = {1'b0, a[i*CW +: CW]};
		end else begin : g_hi
			assign ax = (CW+1)'($signed(a[WA-1 -: LW]));
		end
		always_ff @(posedge clk) begin
			part_s1[i] <= ax * $signed({1'b0, b});
		end
	end

	// Shifted sum of the partials
	always_comb begin
		sum = '0;
		for (int i = 0; i < NC; i++) begin
			sum = sum + (PW'(part_s1[i]) <<< (CW * i));
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= sum;
	end

	assign p = p_s2;

endmodule

FILE: rtl/core/mjq_div.sv
// ----------------------------------------------------------------------------
// mjq_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Overflow of the coefficient field is flagged by the caller, which clamps the whole quotient.
// ----------------------------------------------------------------------------
module mjq_div #(
	parameter int NW  = 160,
	parameter int DDW = 97,
	parameter int QB  = 49
) (
	input  logic           clk,
	input  logic [NW-1:0]  num,
	input  logic [DDW-1:0] den,
	input  logic           sgn,
	output logic [QB-1:0]  quo,
	output logic           sgn_o
);
	localparam int CW = mjq_pkg::wmax(NW, DDW + QB);

	logic [NW-1:0]  rem_s [QB+1];
	logic [DDW-1:0] den_s [QB+1];
	logic [QB-1:0]  quo_s [QB+1];
	logic           sgn_s [QB+1];

	// Entry stage
	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		sgn_s[0] <= sgn;
	end

	// One compare and subtract per stage
	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int K = QB - 1 - j;
		logic [CW-1:0] dsh;
		logic          ge;
		assign dsh = CW'(den_s[j]) << K;
		assign ge  = (CW'(rem_s[j]) >= dsh);
		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? NW'(CW'(rem_s[j]) - dsh) : rem_s[j];
			den_s[j+1] <= den_s[j];
			quo_s[j+1] <= {quo_s[j][QB-2:0], ge};
			sgn_s[j+1] <= sgn_s[j];
		end
	end

	assign quo   = quo_s[QB];
	assign sgn_o = sgn_s[QB];

endmodule

FILE: rtl/core/min_jerk_quintic_coeffs.sv
// ----------------------------------------------------------------------------
// min_jerk_quintic_coeffs
// Throughput: one transaction per cycle; busy is never raised.
// The depth is set by the three dividers, one quotient bit per stage.
// Reset clears only the valid bits; no result is lost while running.
// ----------------------------------------------------------------------------
module min_jerk_quintic_coeffs #(
	parameter int FRAC_BITS = mjq_pkg::FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mjq_pkg::in_t  req,
	output logic          done,
	output mjq_pkg::out_t rsp
);
	localparam int W    = mjq_pkg::DATA_W;
	localparam int F    = FRAC_BITS;
	localparam int TW   = mjq_pkg::DUR_W;
	localparam int QB   = W + 1;
	localparam int LAST = 11 + QB;
	localparam int LAT  = 12 + QB;
	localparam int QW   = mjq_pkg::wmax(W + 1 + F, W + TW) + 1;
	localparam int PPW  = mjq_pkg::wmax(W + 2*F + 2, W + F + TW + 1) + 1;
	localparam int EW   = mjq_pkg::wmax(mjq_pkg::wmax(PPW, W + 2*TW + 1), QW + TW) + 1;
	localparam int MW   = EW + 5;
	localparam int NW3  = mjq_pkg::wmax(MW + F, 3*TW) + 1;
	localparam int NW4  = mjq_pkg::wmax(MW + 2*F, 4*TW) + 1;
	localparam int NW5  = mjq_pkg::wmax(MW + 3*F, 5*TW) + 1;

	typedef struct packed {
		logic [W-1:0] c0;
		logic [W-1:0] c1;
		logic [W-1:0] c2;
		logic         tz;
	} side_t;

	// Valid and side data travel alongside the arithmetic
	logic  v_s    [1:LAST];
	side_t side_s [1:LAST];
	logic  done_q;
	mjq_pkg::out_t rsp_q;

	// Stage 1 operands
	logic signed [W-1:0] sv_s1, sa_s1;
	logic signed [W:0]   dpos_s1, dvel_s1, r_s1;
	logic [TW-1:0]       t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7, t_s8;
	logic signed [W:0]   dpos_s2, dpos_s3, dvel_s2, dvel_s3;

	// Product and difference terms
	logic signed [2*TW:0]   t2_w;
	logic signed [W+TW-1:0] svt_w, sat_w;
	logic signed [W+TW:0]   rt_w;
	logic signed [QW-1:0]   q_s4;
	logic signed [PPW-1:0]  pp_s4, pp_s5, pp_s6;
	logic signed [2*TW:0]   t2_s4;
	logic signed [W+TW-1:0] sat_s4;
	logic signed [W+TW:0]   rt_s4;
	logic signed [3*TW:0]   t3_w;
	logic signed [W+2*TW-1:0] sat2_w;
	logic signed [W+2*TW:0]   rt2_w;
	logic signed [QW+TW-1:0]  qt_w;
	logic signed [4*TW:0]   t4_w;
	logic signed [5*TW:0]   t5_w;
	logic signed [EW-1:0]   p_s7;
	logic signed [QW+TW-1:0]  qt_s7;
	logic signed [W+2*TW:0]   rt2_s7;
	logic [3*TW-1:0] t3_s7, t3_s8, t3_s9, t3_s10;
	logic [4*TW-1:0] t4_s9, t4_s10;
	logic signed [MW-1:0] m3_s8, m4_s8, m5_s8;
	logic [MW-1:0] mag3_s9, mag4_s9, mag5_s9, mag3_s10, mag4_s10, mag5_s10;
	logic neg3_s9, neg4_s9, neg5_s9, neg3_s10, neg4_s10, neg5_s10;
	logic [NW3-1:0] n3;
	logic [NW4-1:0] n4;
	logic [NW5-1:0] n5;
	logic [QB-1:0]  q3, q4, q5;
	logic           sg3, sg4, sg5;

	// Half of start acceleration, rounded away from zero
	logic [W-1:0] amag, ahalf, c2;
	always_comb begin
		amag  = req.start_acc[W-1] ? W'(-req.start_acc) : W'(req.start_acc);
		ahalf = W'(((W+1)'(amag) + 1'b1) >> 1);
		c2    = req.start_acc[W-1] ? W'(-ahalf) : ahalf;
	end

	// Valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) v_s[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s[1] <= start;
			for (int i = 2; i <= LAST; i++) v_s[i] <= v_s[i-1];
			done_q <= v_s[LAST];
		end
	end

	// Side data line
	always_ff @(posedge clk) begin
		side_s[1] <= '{c0: req.start_pos, c1: req.start_vel, c2: c2,
			tz: (req.duration == '0)};
		for (int i = 2; i <= LAST; i++) side_s[i] <= side_s[i-1];
	end

	// Stage 1: boundary differences
	always_ff @(posedge clk) begin
		sv_s1   <= req.start_vel;
		sa_s1   <= req.start_acc;
		dpos_s1 <= (W+1)'(req.end_pos) - (W+1)'(req.start_pos);
		dvel_s1 <= (W+1)'(req.end_vel) - (W+1)'(req.start_vel);
		r_s1    <= (W+1)'(req.end_acc) - (W+1)'(req.start_acc);
		t_s1    <= req.duration;
	end

	// Stages 2-3: first products
	mjq_mul #(.WA(TW + 1)) u_t2  (.clk(clk), .a({1'b0, t_s1}), .b(t_s1), .p(t2_w));
	mjq_mul #(.WA(W))      u_svt (.clk(clk), .a(sv_s1), .b(t_s1), .p(svt_w));
	mjq_mul #(.WA(W))      u_sat (.clk(clk), .a(sa_s1), .b(t_s1), .p(sat_w));
	mjq_mul #(.WA(W + 1))  u_rt  (.clk(clk), .a(r_s1), .b(t_s1), .p(rt_w));

	always_ff @(posedge clk) begin
		t_s2 <= t_s1; t_s3 <= t_s2; t_s4 <= t_s3; t_s5 <= t_s4;
		t_s6 <= t_s5; t_s7 <= t_s6; t_s8 <= t_s7;
		dpos_s2 <= dpos_s1; dpos_s3 <= dpos_s2;
		dvel_s2 <= dvel_s1; dvel_s3 <= dvel_s2;
	end

	// Stage 4: velocity residual and position partial
	always_ff @(posedge clk) begin
		q_s4   <= (QW'(dvel_s3) <<< F) - QW'(sat_w);
		pp_s4  <= (PPW'(dpos_s3) <<< (2*F + 1)) - (PPW'(svt_w) <<< (F + 1));
		t2_s4  <= t2_w;
		sat_s4 <= sat_w;
		rt_s4  <= rt_w;
	end

	// Stages 5-6: second products
	mjq_mul #(.WA(2*TW + 1)) u_t3   (.clk(clk), .a(t2_s4), .b(t_s4), .p(t3_w));
	mjq_mul #(.WA(W + TW))   u_sat2 (.clk(clk), .a(sat_s4), .b(t_s4), .p(sat2_w));
	mjq_mul #(.WA(W + TW + 1)) u_rt2 (.clk(clk), .a(rt_s4), .b(t_s4), .p(rt2_w));
	mjq_mul #(.WA(QW))       u_qt   (.clk(clk), .a(q_s4), .b(t_s4), .p(qt_w));

	// Higher powers of T
	mjq_mul #(.WA(3*TW + 1)) u_t4 (.clk(clk), .a(t3_w), .b(t_s6), .p(t4_w));
	mjq_mul #(.WA(4*TW + 1)) u_t5 (.clk(clk), .a(t4_w), .b(t_s8), .p(t5_w));

	always_ff @(posedge clk) begin
		pp_s5 <= pp_s4;
		pp_s6 <= pp_s5;
	end

	// Stage 7: full position residual
	always_ff @(posedge clk) begin
		p_s7   <= EW'(pp_s6) - EW'(sat2_w);
		qt_s7  <= qt_w;
		rt2_s7 <= rt2_w;
		t3_s7  <= t3_w[3*TW-1:0];
	end

	// Stage 8: closed-form numerators (10/-15/6 on p, -8/14/-6 on qT, 1/-2/1 on rT^2)
	logic signed [MW-1:0] pe, qe, re;
	always_comb begin
		pe = MW'(p_s7);
		qe = MW'(qt_s7);
		re = MW'(rt2_s7);
	end
	always_ff @(posedge clk) begin
		m3_s8 <= (pe <<< 3) + (pe <<< 1) - (qe <<< 3) + re;
		m4_s8 <= (qe <<< 4) - (qe <<< 1) - ((pe <<< 4) - pe) - (re <<< 1);
		m5_s8 <= (pe <<< 2) + (pe <<< 1) - ((qe <<< 2) + (qe <<< 1)) + re;
		t3_s8 <= t3_s7;
	end

	// Stage 9: sign and magnitude
	always_ff @(posedge clk) begin
		neg3_s9 <= m3_s8[MW-1];
		neg4_s9 <= m4_s8[MW-1];
		neg5_s9 <= m5_s8[MW-1];
		mag3_s9 <= m3_s8[MW-1] ? MW'(-m3_s8) : MW'(m3_s8);
		mag4_s9 <= m4_s8[MW-1] ? MW'(-m4_s8) : MW'(m4_s8);
		mag5_s9 <= m5_s8[MW-1] ? MW'(-m5_s8) : MW'(m5_s8);
		t3_s9   <= t3_s8;
		t4_s9   <= t4_w[4*TW-1:0];
	end

	// Stage 10: align with T^5
	always_ff @(posedge clk) begin
		neg3_s10 <= neg3_s9; neg4_s10 <= neg4_s9; neg5_s10 <= neg5_s9;
		mag3_s10 <= mag3_s9; mag4_s10 <= mag4_s9; mag5_s10 <= mag5_s9;
		t3_s10   <= t3_s9;
		t4_s10   <= t4_s9;
	end

	// Rounding offset T^k added before dividing by 2 T^k
	always_comb begin
		n3 = (NW3'(mag3_s10) << F) + NW3'(t3_s10);
		n4 = (NW4'(mag4_s10) << (2*F)) + NW4'(t4_s10);
		n5 = (NW5'(mag5_s10) << (3*F)) + NW5'(t5_w[5*TW-1:0]);
	end

	mjq_div #(.NW(NW3), .DDW(3*TW + 1), .QB(QB)) u_div3 (
		.clk(clk), .num(n3), .den({t3_s10, 1'b0}), .sgn(neg3_s10),
		.quo(q3), .sgn_o(sg3));
	mjq_div #(.NW(NW4), .DDW(4*TW + 1), .QB(QB)) u_div4 (
		.clk(clk), .num(n4), .den({t4_s10, 1'b0}), .sgn(neg4_s10),
		.quo(q4), .sgn_o(sg4));
	mjq_div #(.NW(NW5), .DDW(5*TW + 1), .QB(QB)) u_div5 (
		.clk(clk), .num(n5), .den({t5_w[5*TW-1:0], 1'b0}), .sgn(neg5_s10),
		.quo(q5), .sgn_o(sg5));

	// Output stage: saturate, zero-duration override
	logic [W:0] r3, r4, r5;
	always_comb begin
		r3 = mjq_pkg::sat_coef(q3, sg3);
		r4 = mjq_pkg::sat_coef(q4, sg4);
		r5 = mjq_pkg::sat_coef(q5, sg5);
	end

	always_ff @(posedge clk) begin
		rsp_q.coef0 <= side_s[LAST].c0;
		rsp_q.coef1 <= side_s[LAST].c1;
		rsp_q.coef2 <= side_s[LAST].c2;
		rsp_q.coef3 <= side_s[LAST].tz ? '0 : r3[W-1:0];
		rsp_q.coef4 <= side_s[LAST].tz ? '0 : r4[W-1:0];
		rsp_q.coef5 <= side_s[LAST].tz ? '0 : r5[W-1:0];
		rsp_q.fault <= side_s[LAST].tz | r3[W] | r4[W] | r5[W];
	end

	assign busy = 1'b0;
	assign done = done_q;
	assign rsp  = rsp_q;

	// Every accepted transaction yields one done strobe with its result
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result missing after accepted transaction");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without matching transaction");

	a_zero_dur: assert property (@(posedge clk) disable iff (!arst_n)
		(start && req.duration == '0) |-> ##LAT (done && rsp.fault &&
			rsp.coef3 == '0 && rsp.coef4 == '0 && rsp.coef5 == '0))
		else $error("zero duration not flagged");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum-jerk quintic coefficient pipeline.
// A directed table covers zero duration, extreme fields and saturation, and
// random boundary sets follow. Each accepted transaction's result is taken from the table or
// predicted with wide exact integer arithmetic, and checked against the done strobe in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W    = mjq_pkg::DATA_W;
	localparam int DUR_W     = mjq_pkg::DUR_W;
	localparam int FRAC_BITS = mjq_pkg::FRAC_BITS;

	typedef mjq_pkg::in_t  in_t;
	typedef mjq_pkg::out_t out_t;

	localparam int WW        = 256;
	localparam int N_RAND    = 1800;
	localparam int TAIL      = 150;
	localparam int LATENCY   = DATA_W + 13;
	localparam int LIMIT     = 200000;
	localparam logic [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DUR_W-1:0]  ONE_T = DUR_W'(1) << FRAC_BITS;

	typedef logic signed [WW-1:0] wide_t;
	typedef struct {
		in_t  req;
		bit   typed;
		out_t rsp;
	} row_t;

	logic clk, arst_n, start, busy, done;
	in_t  req;
	out_t rsp;

	out_t   cur_coefs;
	out_t   coef_queue[$];
	row_t   rows[$];
	int     bad = 0;
	longint cycles = 0;

	min_jerk_quintic_coeffs dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Sign-extend one boundary field to the wide working width
	function automatic wide_t sx(logic [DATA_W-1:0] v);
		return {{(WW-DATA_W){v[DATA_W-1]}}, v};
	endfunction

	// round(m * 2^s / (2 tk)) half away from zero, clamped to the coefficient range
	function automatic logic [DATA_W-1:0] round_clamp(wide_t m, int s, wide_t tk,
			inout bit sat);
		logic [WW-1:0]     mag, q;
		logic [WW-1:0]     lim;
		bit                neg;
		neg = m[WW-1];
		mag = neg ? -m : m;
		q   = ((mag << s) + tk) / (tk << 1);
		lim = WW'(1) << (DATA_W-1);
		if (neg) begin
			if (q > lim) begin
				sat = 1'b1;
				return MIN_V;
			end
			return -q[DATA_W-1:0];
		end
		if (q >= lim) begin
			sat = 1'b1;
			return MAX_V;
		end
		return q[DATA_W-1:0];
	endfunction

	// Expected coefficients for one boundary set
	function automatic out_t quintic_coefs(in_t x);
		out_t           o;
		logic [DATA_W:0] amag;
		wide_t          sp, sv, sa, ep, ev, ea, t, t2, t3, t4, t5;
		wide_t          p, q, r, qt, rt2, m3, m4, m5;
		bit             sat;
		sat  = 1'b0;
		amag = x.start_acc[DATA_W-1] ? -{1'b1, x.start_acc} : {1'b0, x.start_acc};
		amag = (amag + 1'b1) >> 1;
		o.coef0 = x.start_pos;
		o.coef1 = x.start_vel;
		o.coef2 = x.start_acc[DATA_W-1] ? -amag[DATA_W-1:0] : amag[DATA_W-1:0];
		if (x.duration == '0) begin
			o.coef3 = '0;
			o.coef4 = '0;
			o.coef5 = '0;
			o.fault = 1'b1;
			return o;
		end
		sp = sx(x.start_pos); sv = sx(x.start_vel); sa = sx(x.start_acc);
		ep = sx(x.end_pos);   ev = sx(x.end_vel);   ea = sx(x.end_acc);
		t  = {{(WW-DUR_W){1'b0}}, x.duration};
		t2 = t * t; t3 = t2 * t; t4 = t3 * t; t5 = t4 * t;
		// scaled residuals: p = 2 B0 2^3F, q = B1 2^2F, r = B2 2^F
		p   = ((ep - sp) <<< (2*FRAC_BITS + 1)) - ((sv * t) <<< (FRAC_BITS + 1)) - sa * t2;
		q   = ((ev - sv) <<< FRAC_BITS) - sa * t;
		r   = ea - sa;
		qt  = q * t;
		rt2 = r * t2;
		m3  = 10 * p - 8 * qt + rt2;
		m4  = 14 * qt - 15 * p - 2 * rt2;
		m5  = 6 * p - 6 * qt + rt2;
		o.coef3 = round_clamp(m3, FRAC_BITS, t3, sat);
		o.coef4 = round_clamp(m4, 2*FRAC_BITS, t4, sat);
		o.coef5 = round_clamp(m5, 3*FRAC_BITS, t5, sat);
		o.fault = sat;
		return o;
	endfunction

	function automatic in_t bset(logic [DATA_W-1:0] sp, logic [DATA_W-1:0] sv,
			logic [DATA_W-1:0] sa, logic [DATA_W-1:0] ep, logic [DATA_W-1:0] ev,
			logic [DATA_W-1:0] ea, logic [DUR_W-1:0] d);
		in_t x;
		x.start_pos = sp; x.start_vel = sv; x.start_acc = sa;
		x.end_pos = ep; x.end_vel = ev; x.end_acc = ea; x.duration = d;
		return x;
	endfunction

	function automatic void add_row(in_t x, bit typed, out_t o);
		row_t rw;
		rw.req = x; rw.typed = typed; rw.rsp = o;
		rows = {rows, rw};
	endfunction

	function automatic out_t zero_dur(logic [DATA_W-1:0] c0, logic [DATA_W-1:0] c1,
			logic [DATA_W-1:0] c2);
		out_t o;
		o = '0;
		o.coef0 = c0; o.coef1 = c1; o.coef2 = c2; o.fault = 1'b1;
		return o;
	endfunction

	// Random field: mostly moderate magnitudes, some extremes and full range
	function automatic logic [DATA_W-1:0] rand_field();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return MAX_V;
			1: return MIN_V;
			2: return '0;
			3, 4: return v[DATA_W-1:0];
			default: return DATA_W'($signed(v[35:0]));
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] rand_dur();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom;
			2: return $urandom_range(1, 255);
			default: return $urandom_range(1 << 22, 1 << 28);
		endcase
	endfunction

	task automatic report(out_t got, out_t exp);
		bad++;
		if (bad <= 10) begin
			$display("mismatch @%0t: got c0=%h c1=%h c2=%h c3=%h c4=%h c5=%h f=%b",
				$realtime, got.coef0, got.coef1, got.coef2, got.coef3, got.coef4,
				got.coef5, got.fault);
			$display("  expected c0=%h c1=%h c2=%h c3=%h c4=%h c5=%h f=%b",
				exp.coef0, exp.coef1, exp.coef2, exp.coef3, exp.coef4,
				exp.coef5, exp.fault);
		end
	endtask

	// Result checker and acceptance tracker
	always @(posedge clk) begin
		out_t exp;
		if (arst_n) begin
			if (done) begin
				if (coef_queue.size() == 0) begin
					report(rsp, '0);
				end else begin
					exp = coef_queue.pop_front();
					if (rsp.coef0 !== exp.coef0 || rsp.coef1 !== exp.coef1 ||
							rsp.coef2 !== exp.coef2 || rsp.coef3 !== exp.coef3 ||
							rsp.coef4 !== exp.coef4 || rsp.coef5 !== exp.coef5 ||
							rsp.fault !== exp.fault)
						report(rsp, exp);
				end
			end
			if (start && !busy)
				coef_queue = {coef_queue, cur_coefs};
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Drive one transaction and hold start until it is taken
	task automatic send(in_t x, out_t exp, bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = x;
		cur_coefs = exp;
		start     = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		in_t x;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		cur_coefs = '0;

		// directed table
		add_row(bset('0, '0, '0, '0, '0, '0, '0), 1'b1, zero_dur('0, '0, '0));
		add_row(bset(MAX_V, MAX_V, MAX_V, MAX_V, MAX_V, MAX_V, '0), 1'b1,
			zero_dur(MAX_V, MAX_V, DATA_W'(1) << (DATA_W-2)));
		add_row(bset(MIN_V, MIN_V, MIN_V, MIN_V, MIN_V, MIN_V, '0), 1'b1,
			zero_dur(MIN_V, MIN_V, {2'b11, {(DATA_W-2){1'b0}}}));
		add_row(bset('0, '0, '1, '0, '0, '0, '0), 1'b1, zero_dur('0, '0, '1));
		add_row(bset('0, '0, DATA_W'(1), '0, '0, '0, '0), 1'b1,
			zero_dur('0, '0, DATA_W'(1)));
		add_row(bset('0, '0, '0, '0, '0, '0, ONE_T), 1'b0, '0);
		add_row(bset('0, '0, '0, DATA_W'(1) << FRAC_BITS, '0, '0, ONE_T), 1'b0, '0);
		add_row(bset('0, '0, '0, MAX_V, '0, '0, DUR_W'(1)), 1'b0, '0);
		add_row(bset('0, '0, '0, MIN_V, '0, '0, DUR_W'(1)), 1'b0, '0);
		add_row(bset(MAX_V, MAX_V, MAX_V, MAX_V, MAX_V, MAX_V, '1), 1'b0, '0);
		add_row(bset(MIN_V, MIN_V, MIN_V, MIN_V, MIN_V, MIN_V, '1), 1'b0, '0);
		add_row(bset(MAX_V, '0, '0, MIN_V, '0, '0, ONE_T), 1'b0, '0);
		add_row(bset('0, MAX_V, '0, '0, '0, '0, 32'h8000_0000), 1'b0, '0);
		add_row(bset('0, '0, '0, '0, '0, MIN_V, DUR_W'(1) << 20), 1'b0, '0);
		add_row(bset(DATA_W'(5) << 24, -(DATA_W'(3) << 23), DATA_W'(1) << 22,
			DATA_W'(40) << 24, DATA_W'(2) << 24, '0, 3 * ONE_T), 1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send(rows[i].req, rows[i].typed ? rows[i].rsp : quintic_coefs(rows[i].req),
				1'b1);

		for (int n = 0; n < N_RAND; n++) begin
			// drain once mid-run with the sender held off
			if (n == N_RAND / 2) begin
				start = 1'b0;
				while (coef_queue.size() != 0) @(negedge clk);
			end
			x = bset(rand_field(), rand_field(), rand_field(), rand_field(),
				rand_field(), rand_field(), rand_dur());
			send(x, quintic_coefs(x), n < N_RAND - TAIL);
		end
		start = 1'b0;

		while (coef_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (bad == 0 && coef_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
